// File: src/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg
// Shared widths, register indexes and controller/datapath signal groups for
// the multichannel moving average core.
// ----------------------------------------------------------------------------
package mma_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int CH_BITS     = 3;
	localparam int CNT_W       = 7;
	localparam int CHCFG_W     = 4;
	localparam int CFG_W       = 7;
	localparam int CFG_IDX_W   = 2;
	localparam int AVG_BITS    = 24;
	localparam int FRAC_BITS   = 8;
	localparam int IN_W        = 24;
	localparam int OUT_W       = 32;

	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = CFG_IDX_W'(1);

	localparam logic [CHCFG_W-1:0] CHANNELS_RESET = CHCFG_W'(8);
	localparam logic [CNT_W-1:0]   WINDOW_RESET   = CNT_W'(64);

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef struct packed {
		logic latch;
		logic read;
		logic update;
		logic start;
		logic load;
	} mma_cmd_t;

	typedef struct packed {
		logic reject;
		logic div_busy;
		logic out_free;
	} mma_stat_t;

endpackage

// File: src/multichannel_moving_average_core.sv
// ----------------------------------------------------------------------------
// multichannel_moving_average_core
// Per-channel moving average of signed samples with a fixed-point result.
// ----------------------------------------------------------------------------
// Sequence: each input beat is latched, then the ring is read, the channel
//   updated and the serial divider started; the result is emitted once it is done.
// A new input beat is accepted only after the previous item has been emitted.
// A rejected channel skips the ring read, update and divide and goes to emit.
// Reset: asynchronous; clears all sums, pointers and counts, restores
//   channels_in_use to 8 and window_len to 64. A write to either register clears too.
// ----------------------------------------------------------------------------
module multichannel_moving_average_core import mma_pkg::*; #(
	parameter int MAX_CHANNELS = 8,
	parameter int MAX_WINDOW   = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_W-1:0]      s_tdata,   // channel[2:0], sample[18:3], zero pad
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata    // status[0], average[24:1], samples_held[31:25]
);

	mma_cmd_t  cmd;
	mma_stat_t stat;

	mma_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	mma_datapath #(
		.MAX_CHANNELS(MAX_CHANNELS),
		.MAX_WINDOW  (MAX_WINDOW)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule

// File: src/mma_divider.sv
// ----------------------------------------------------------------------------
// mma_divider
// Radix-2 restoring divider for unsigned operands, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mma_divider #(
	parameter int DVD_W = 31,
	parameter int DVS_W = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic [DVD_W-1:0] quotient
);

	localparam int IT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;
	logic [IT_W-1:0]  iter_q;
	logic             busy_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			iter_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			iter_q <= '0;
		end else if (busy_q) begin
			iter_q <= iter_q + 1'b1;
			if (iter_q == IT_W'(DVD_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// File: src/mma_datapath.sv
// ----------------------------------------------------------------------------
// mma_datapath
// Configuration registers, per-channel sums, pointers and counts, the sample
// ring memory, the average divider and the output register.
// ----------------------------------------------------------------------------
module mma_datapath import mma_pkg::*; #(
	parameter int MAX_CHANNELS = 8,
	parameter int MAX_WINDOW   = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [IN_W-1:0]      s_tdata,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 m_tready,
	output logic                 m_tvalid,
	output logic [OUT_W-1:0]     m_tdata,
	input  mma_cmd_t             cmd,
	output mma_stat_t            stat
);

	localparam int CH_IW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CHX_W  = (CH_IW > CH_BITS) ? CH_IW : CH_BITS;
	localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int DEPTH  = MAX_CHANNELS * MAX_WINDOW;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SUM_W  = SAMPLE_BITS + PTR_W + 1;
	localparam int DIVD_W = SUM_W + FRAC_BITS;
	localparam int CMP_W  = (PTR_W + 1 > CNT_W) ? PTR_W + 1 : CNT_W;
	localparam int AW     = (DIVD_W + 1 > AVG_BITS + 1) ? DIVD_W + 1 : AVG_BITS + 1;

	localparam logic [AW-1:0] AMAX_X = AW'((64'd1 << (AVG_BITS - 1)) - 64'd1);
	localparam logic [AW-1:0] AMIN_X = AW'(64'd1 << (AVG_BITS - 1));

	// configuration
	logic [CHCFG_W-1:0] chan_q;
	logic [CNT_W-1:0]   window_q;
	logic [CNT_W-1:0]   win_eff;
	logic               cfg_clear;

	// latched item
	logic [CH_BITS-1:0]            ch_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                          reject_q;
	logic [CH_BITS-1:0]            ch_in;
	logic                          reject_in;
	logic [CHX_W-1:0]              ch_x;
	logic [CH_IW-1:0]              ch_i;

	// channel state
	logic signed [SUM_W-1:0] sum_q [MAX_CHANNELS];
	logic [PTR_W-1:0]        ptr_q [MAX_CHANNELS];
	logic [CNT_W-1:0]        cnt_q [MAX_CHANNELS];

	// ring memory
	logic signed [SAMPLE_BITS-1:0] ring [DEPTH];
	logic signed [SAMPLE_BITS-1:0] rd_q;
	logic [ADDR_W-1:0]             addr;
	logic [ADDR_W-1:0]             addr_q;

	// update
	logic                          full;
	logic signed [SAMPLE_BITS-1:0] old_s;
	logic signed [SUM_W-1:0]       sum_nx;
	logic [CNT_W-1:0]              cnt_nx;
	logic [CMP_W-1:0]              ptr_inc;
	logic [PTR_W-1:0]              ptr_nx;
	logic [CNT_W-1:0]              cnt_res_q;

	// divide
	logic signed [SUM_W-1:0] sum_cur;
	logic [SUM_W-1:0]        sum_mag;
	logic [DIVD_W-1:0]       dividend;
	logic                    neg_q;
	logic                    div_busy;
	logic [DIVD_W-1:0]       quotient;

	// output
	logic [AW-1:0]       q_x;
	logic [AW-1:0]       q_neg;
	logic [AVG_BITS-1:0] avg;
	logic                m_tvalid_q;
	logic [OUT_W-1:0]    m_tdata_q;

	assign cfg_clear = cfg_we && (cfg_index == REG_CHANNELS || cfg_index == REG_WINDOW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q   <= CHANNELS_RESET;
			window_q <= WINDOW_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CHANNELS: chan_q   <= cfg_wdata[CHCFG_W-1:0];
				REG_WINDOW:   window_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (window_q == '0) begin
			win_eff = CNT_W'(1);
		end else if (int'(window_q) > MAX_WINDOW) begin
			win_eff = CNT_W'(MAX_WINDOW);
		end else begin
			win_eff = window_q;
		end
	end

	assign ch_in     = s_tdata[CH_BITS-1:0];
	assign reject_in = (int'(ch_in) >= MAX_CHANNELS) || (CHCFG_W'(ch_in) >= chan_q);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			ch_q     <= ch_in;
			sample_q <= s_tdata[CH_BITS +: SAMPLE_BITS];
			reject_q <= reject_in;
		end
	end

	assign ch_x = CHX_W'(ch_q);
	assign ch_i = ch_x[CH_IW-1:0];
	assign addr = ADDR_W'(int'(ch_i) * MAX_WINDOW + int'(ptr_q[ch_i]));

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			rd_q   <= ring[addr];
			addr_q <= addr;
		end
		if (cmd.update) begin
			ring[addr_q] <= sample_q;
		end
	end

	// slot under the pointer holds a live sample only once the window is full
	always_comb begin
		full    = cnt_q[ch_i] >= win_eff;
		old_s   = full ? rd_q : '0;
		sum_nx  = sum_q[ch_i] - SUM_W'(old_s) + SUM_W'(sample_q);
		cnt_nx  = full ? win_eff : CNT_W'(cnt_q[ch_i] + 1'b1);
		ptr_inc = CMP_W'(ptr_q[ch_i]) + 1'b1;
		ptr_nx  = (ptr_inc >= CMP_W'(win_eff)) ? '0 : PTR_W'(ptr_inc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				sum_q[i] <= '0;
				ptr_q[i] <= '0;
				cnt_q[i] <= '0;
			end
		end else if (cfg_clear) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				sum_q[i] <= '0;
				ptr_q[i] <= '0;
				cnt_q[i] <= '0;
			end
		end else if (cmd.update) begin
			sum_q[ch_i] <= sum_nx;
			ptr_q[ch_i] <= ptr_nx;
			cnt_q[ch_i] <= cnt_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			cnt_res_q <= cnt_nx;
		end
		if (cmd.start) begin
			neg_q <= sum_cur[SUM_W-1];
		end
	end

	assign sum_cur  = sum_q[ch_i];
	assign sum_mag  = sum_cur[SUM_W-1] ? SUM_W'(-sum_cur) : SUM_W'(sum_cur);
	assign dividend = {sum_mag, {FRAC_BITS{1'b0}}};

	mma_divider #(
		.DVD_W(DIVD_W),
		.DVS_W(CNT_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.start),
		.dividend(dividend),
		.divisor (cnt_res_q),
		.busy    (div_busy),
		.quotient(quotient)
	);

	// negate and saturate to the average range; zero for a rejected channel
	always_comb begin
		q_x   = AW'(quotient);
		q_neg = -q_x;
		if (reject_q) begin
			avg = '0;
		end else if (neg_q) begin
			avg = (q_x > AMIN_X) ? AMIN_X[AVG_BITS-1:0] : q_neg[AVG_BITS-1:0];
		end else begin
			avg = (q_x > AMAX_X) ? AMAX_X[AVG_BITS-1:0] : q_x[AVG_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_tdata_q <= {reject_q ? '0 : cnt_res_q, avg,
				reject_q ? STATUS_ERR : STATUS_OK};
		end
	end

	assign m_tvalid      = m_tvalid_q;
	assign m_tdata       = m_tdata_q;
	assign stat.reject   = reject_q;
	assign stat.div_busy = div_busy;
	assign stat.out_free = !m_tvalid_q || m_tready;

endmodule

// File: src/mma_ctrl.sv
// ----------------------------------------------------------------------------
// mma_ctrl
// Sequencer for one item: latch, ring read, channel update, divide, emit; a rejected item skips to emit.
// ----------------------------------------------------------------------------
module mma_ctrl import mma_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  mma_stat_t stat,
	output mma_cmd_t  cmd
);

	typedef enum logic [2:0] {
		IDLE,
		READ,
		UPDATE,
		START,
		DIVIDE,
		EMIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			case (state_q)
				IDLE:    if (s_tvalid) state_q <= READ;
				READ:    state_q <= stat.reject ? EMIT : UPDATE;
				UPDATE:  state_q <= START;
				START:   state_q <= DIVIDE;
				DIVIDE:  if (!stat.div_busy) state_q <= EMIT;
				EMIT:    if (stat.out_free) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

	assign s_tready   = state_q == IDLE;
	assign cmd.latch  = (state_q == IDLE) && s_tvalid;
	assign cmd.read   = (state_q == READ) && !stat.reject;
	assign cmd.update = state_q == UPDATE;
	assign cmd.start  = state_q == START;
	assign cmd.load   = (state_q == EMIT) && stat.out_free;

endmodule
